// ----- src/fsac_pkg.sv -----
// ----------------------------------------------------------------------------
// fsac_pkg
// Shared types and constants for the fan speed and alarm controller.
// ----------------------------------------------------------------------------
package fsac_pkg;

  localparam int TICK_COUNTER_WIDTH = 16;
  localparam int TONE_TICKS_W       = 16;
  localparam int TICK_CMP_W         = (TICK_COUNTER_WIDTH > TONE_TICKS_W) ?
                                      TICK_COUNTER_WIDTH : TONE_TICKS_W;
  localparam int CFG_ADDR_W         = 5;
  localparam int CFG_DATA_W         = 32;
  localparam int CFG_IDX_W          = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SET_POINT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_QUIET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_ALARM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_ON    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_OFF   = 3'd5;

  localparam logic [1:0] FAN_STOPPED = 2'd0;
  localparam logic [1:0] FAN_LOW     = 2'd1;
  localparam logic [1:0] FAN_HIGH    = 2'd2;

  typedef struct packed {
    logic signed [8:0] temperature_deg;
    logic [9:0]        battery_decivolts;
    logic              ac_request;
    logic              pressure_request;
  } in_req_t;

  typedef struct packed {
    logic [1:0] fan_speed;
    logic       over_temperature;
    logic       buzzer_enabled;
    logic       tone_active;
  } out_req_t;

  typedef struct packed {
    logic [7:0]              set_point;
    logic [4:0]              hysteresis_band;
    logic [9:0]              volt_quiet_limit;
    logic [9:0]              volt_alarm_level;
    logic [TONE_TICKS_W-1:0] tone_on_ticks;
    logic [TONE_TICKS_W-1:0] tone_off_ticks;
  } cfg_t;

endpackage

// ----- src/fsac_regs.sv -----
// ----------------------------------------------------------------------------
// fsac_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module fsac_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fsac_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [fsac_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [fsac_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output fsac_pkg::cfg_t                 cfg
);
  import fsac_pkg::*;

  cfg_t                 cfg_r;
  logic [CFG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_point        <= 8'd90;
      cfg_r.hysteresis_band  <= 5'd3;
      cfg_r.volt_quiet_limit <= 10'd150;
      cfg_r.volt_alarm_level <= 10'd155;
      cfg_r.tone_on_ticks    <= TONE_TICKS_W'(500);
      cfg_r.tone_off_ticks   <= TONE_TICKS_W'(500);
    end else if (wr_en) begin
      case (idx)
        REG_SET_POINT:  cfg_r.set_point        <= pwdata[7:0];
        REG_HYSTERESIS: cfg_r.hysteresis_band  <= pwdata[4:0];
        REG_VOLT_QUIET: cfg_r.volt_quiet_limit <= pwdata[9:0];
        REG_VOLT_ALARM: cfg_r.volt_alarm_level <= pwdata[9:0];
        REG_TONE_ON:    cfg_r.tone_on_ticks    <= pwdata[TONE_TICKS_W-1:0];
        REG_TONE_OFF:   cfg_r.tone_off_ticks   <= pwdata[TONE_TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SET_POINT:  prdata = CFG_DATA_W'(cfg_r.set_point);
      REG_HYSTERESIS: prdata = CFG_DATA_W'(cfg_r.hysteresis_band);
      REG_VOLT_QUIET: prdata = CFG_DATA_W'(cfg_r.volt_quiet_limit);
      REG_VOLT_ALARM: prdata = CFG_DATA_W'(cfg_r.volt_alarm_level);
      REG_TONE_ON:    prdata = CFG_DATA_W'(cfg_r.tone_on_ticks);
      REG_TONE_OFF:   prdata = CFG_DATA_W'(cfg_r.tone_off_ticks);
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- src/fsac_core.sv -----
// ----------------------------------------------------------------------------
// fsac_core
// Buzzer, tone timer and fan state machine; state advances once per tick.
// ----------------------------------------------------------------------------
module fsac_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  fsac_pkg::in_req_t  req,
  input  fsac_pkg::cfg_t     cfg,
  output fsac_pkg::out_req_t res
);
  import fsac_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_LOW   = 2'd1,
    MODE_HIGH  = 2'd2,
    MODE_ALARM = 2'd3
  } mode_t;

  mode_t                         mode_r, mode_nxt;
  logic                          buzzer_r, buzzer_nxt;
  logic                          tone_r, tone_nxt;
  logic [TICK_COUNTER_WIDTH-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic                          pulse_fire;
  logic signed [10:0]            temp_s, sp_s, hy_s;
  logic signed [10:0]            thr_lo, thr_hi1, thr_hi2, thr_hi2m1;

  assign cnt_inc   = (cnt_r != '1) ? cnt_r + 1'b1 : cnt_r;
  assign temp_s    = 11'(req.temperature_deg);
  assign sp_s      = signed'({3'b000, cfg.set_point});
  assign hy_s      = signed'({6'b000000, cfg.hysteresis_band});
  assign thr_lo    = sp_s - hy_s;
  assign thr_hi1   = sp_s + hy_s;
  assign thr_hi2   = sp_s + hy_s + hy_s;
  assign thr_hi2m1 = thr_hi2 - 11'sd1;

  always_comb begin
    buzzer_nxt = buzzer_r;
    tone_nxt   = tone_r;
    cnt_nxt    = cnt_inc;
    mode_nxt   = mode_r;
    pulse_fire = 1'b0;

    if (req.battery_decivolts <= cfg.volt_quiet_limit && mode_r != MODE_ALARM
        && buzzer_nxt) begin
      buzzer_nxt = 1'b0;
      tone_nxt   = 1'b0;
    end
    if (req.battery_decivolts > cfg.volt_alarm_level && !buzzer_nxt) begin
      buzzer_nxt = 1'b1;
      tone_nxt   = 1'b1;
    end

    if (buzzer_nxt) begin
      if (tone_nxt) begin
        if (TICK_CMP_W'(cnt_inc) > TICK_CMP_W'(cfg.tone_on_ticks)) begin
          cnt_nxt    = '0;
          tone_nxt   = 1'b0;
          pulse_fire = 1'b1;
        end
      end else begin
        if (TICK_CMP_W'(cnt_inc) > TICK_CMP_W'(cfg.tone_off_ticks)) begin
          cnt_nxt    = '0;
          tone_nxt   = 1'b1;
          pulse_fire = 1'b1;
        end
      end
    end

    unique case (mode_r)
      MODE_IDLE: begin
        if (temp_s >= sp_s || req.ac_request || req.pressure_request) begin
          mode_nxt = MODE_LOW;
        end
      end
      MODE_LOW: begin
        if (temp_s <= thr_lo && !req.ac_request && !req.pressure_request) begin
          mode_nxt = MODE_IDLE;
        end
        if (temp_s >= thr_hi1 || req.pressure_request) begin
          mode_nxt = MODE_HIGH;
        end
      end
      MODE_HIGH: begin
        if (temp_s <= sp_s && !req.pressure_request) begin
          mode_nxt = MODE_LOW;
        end
        if (temp_s >= thr_hi2) begin
          mode_nxt = MODE_ALARM;
          if (!buzzer_nxt) begin
            buzzer_nxt = 1'b1;
            tone_nxt   = 1'b1;
          end
        end
      end
      MODE_ALARM: begin
        if (temp_s <= thr_hi2m1) begin
          mode_nxt = MODE_HIGH;
          if (buzzer_nxt) begin
            buzzer_nxt = 1'b0;
            tone_nxt   = 1'b0;
          end
        end
      end
    endcase

    unique case (mode_nxt)
      MODE_IDLE: res.fan_speed = FAN_STOPPED;
      MODE_LOW:  res.fan_speed = FAN_LOW;
      default:   res.fan_speed = FAN_HIGH;
    endcase
    res.over_temperature = (mode_nxt == MODE_ALARM);
    res.buzzer_enabled   = buzzer_nxt;
    res.tone_active      = tone_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      buzzer_r <= 1'b0;
      tone_r   <= 1'b0;
      cnt_r    <= '0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      buzzer_r <= buzzer_nxt;
      tone_r   <= tone_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_tone_needs_buzzer: assert property (@(posedge clk) disable iff (!rst_n)
    tone_r |-> buzzer_r)
    else $error("tone sounding while the buzzer is off");

  a_alarm_buzzer_on: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ALARM) |-> buzzer_r)
    else $error("alarm state without the buzzer enabled");

  a_toggle_restarts_count: assert property (@(posedge clk) disable iff (!rst_n)
    (step && pulse_fire) |=> (cnt_r == '0))
    else $error("tick count not restarted after a tone toggle");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(mode_r) && $stable(cnt_r) && $stable(buzzer_r)))
    else $error("controller state changed without a tick");
`endif

endmodule

// ----- src/fan_speed_alarm_controller_unit.sv -----
// ----------------------------------------------------------------------------
// fan_speed_alarm_controller_unit
// Per-tick fan speed and battery alarm controller with an APB-style
// configuration port.
//
//   Channel   Ports                               Moves
//   input     in_valid, in_ready, in_data         one tick request
//   result    out_valid, out_ready, out_data      one result request per tick
//   config    psel, penable, pwrite, paddr, ...   register writes and reads
//
// A request is registered on acceptance and its result is registered when it
// advances, and one request is taken per cycle while the result is not stalled.
// The controller state updates together with the result register, as a
// request moves between the two registers. Reset clears the state and loads
// the register defaults. A stalled result holds the input register, which
// then accepts again once the result is taken.
// ----------------------------------------------------------------------------
module fan_speed_alarm_controller_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fsac_pkg::in_req_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fsac_pkg::out_req_t              out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fsac_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [fsac_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [fsac_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import fsac_pkg::*;

  cfg_t     cfg;
  in_req_t  s1_data_r;
  logic     s1_vld_r;
  out_req_t res;
  out_req_t out_data_r;
  logic     out_valid_r;
  logic     out_free;
  logic     advance;

  assign out_free  = !out_valid_r || out_ready;
  assign advance   = s1_vld_r && out_free;
  assign in_ready  = !s1_vld_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  fsac_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fsac_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .req   (s1_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_vld_r <= 1'b1;
      end else if (advance) begin
        s1_vld_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

endmodule
